// ===== rtl/tcc_pkg.sv =====
// tcc_pkg: shared constants and helpers for the tetrahedron circumcenter block
// depends on nothing; imported by tcc_mul and tetra_circumcenter
package tcc_pkg;

	// bits of the second operand consumed per multiplier stage
	localparam int MUL_CHUNK = 16;

	// number of pipeline stages of tcc_mul for a second operand of bw bits
	function automatic int mul_stages(input int bw);
		return (bw + MUL_CHUNK - 1) / MUL_CHUNK;
	endfunction

endpackage

// ===== rtl/tcc_mul.sv =====
// tcc_mul: pipelined signed multiplier, one chunk of operand b per stage
// depends on tcc_pkg (MUL_CHUNK, mul_stages)
module tcc_mul #(
	parameter int AW = 70,
	parameter int BW = 67
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	import tcc_pkg::*;

	localparam int NS = mul_stages(BW);
	localparam int BX = NS * MUL_CHUNK;
	localparam int PW = AW + BW;

	logic signed [AW-1:0] a_q   [NS];
	logic signed [BX-1:0] b_q   [NS];
	logic signed [PW-1:0] acc_q [NS];

	for (genvar j = 0; j < NS; j++) begin : g_st
		logic signed [AW-1:0]      a_in;
		logic signed [BX-1:0]      b_in;
		logic signed [PW-1:0]      acc_in;
		logic signed [PW-1:0]      pp;
		logic [MUL_CHUNK-1:0]      ch;
		logic signed [MUL_CHUNK:0] ch_s;

		if (j == 0) begin : g_first
			assign a_in   = a;
			assign b_in   = BX'(b);
			assign acc_in = '0;
		end else begin : g_next
			assign a_in   = a_q[j-1];
			assign b_in   = b_q[j-1];
			assign acc_in = acc_q[j-1];
		end

		// top chunk carries the sign, the others are unsigned
		assign ch = b_in[j*MUL_CHUNK +: MUL_CHUNK];
		if (j == NS - 1) begin : g_top
			assign ch_s = {ch[MUL_CHUNK-1], ch};
		end else begin : g_low
			assign ch_s = {1'b0, ch};
		end
		assign pp = a_in * ch_s;

		// accumulate partial product at its weight
		always_ff @(posedge clk) begin
			if (en) begin
				a_q[j]   <= a_in;
				b_q[j]   <= b_in;
				acc_q[j] <= acc_in + (pp <<< (j * MUL_CHUNK));
			end
		end
	end

	assign p = acc_q[NS-1];

endmodule

// ===== rtl/tcc_div.sv =====
// tcc_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing; carries a sideband word alongside the quotient
module tcc_div #(
	parameter int NB  = 139,
	parameter int QB  = 34,
	parameter int SBW = 34
) (
	input  logic           clk,
	input  logic           en,
	input  logic [NB-1:0]  num,
	input  logic [NB-1:0]  den,
	input  logic [SBW-1:0] side,
	output logic [QB-1:0]  quo,
	output logic [SBW-1:0] side_o
);
	localparam int XW = NB + QB;

	logic [NB-1:0]  rem_q  [QB];
	logic [NB-1:0]  den_q  [QB];
	logic [QB-1:0]  quo_q  [QB];
	logic [SBW-1:0] side_q [QB];

	for (genvar i = 0; i < QB; i++) begin : g_st
		localparam int BIT = QB - 1 - i;
		logic [NB-1:0]  rem_in, den_in, rem_nx;
		logic [QB-1:0]  quo_in, quo_nx;
		logic [SBW-1:0] side_in;
		logic [XW-1:0]  rx, dsh;
		logic           ge;

		if (i == 0) begin : g_first
			assign rem_in  = num;
			assign den_in  = den;
			assign quo_in  = '0;
			assign side_in = side;
		end else begin : g_next
			assign rem_in  = rem_q[i-1];
			assign den_in  = den_q[i-1];
			assign quo_in  = quo_q[i-1];
			assign side_in = side_q[i-1];
		end

		// trial subtract of the shifted divisor
		always_comb begin
			rx  = XW'(rem_in);
			dsh = XW'(den_in) << BIT;
			ge  = rx >= dsh;
			rem_nx = ge ? NB'(rx - dsh) : rem_in;
			quo_nx = quo_in;
			quo_nx[BIT] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= rem_nx;
				den_q[i]  <= den_in;
				quo_q[i]  <= quo_nx;
				side_q[i] <= side_in;
			end
		end
	end

	assign quo    = quo_q[QB-1];
	assign side_o = side_q[QB-1];

endmodule

// ===== rtl/tcc_lane.sv =====
// tcc_lane: one axis of the circumcenter: numerator determinant, divide, offset
// depends on tcc_mul and tcc_div
module tcc_lane #(
	parameter int W  = 32,
	parameter int NW = 70,
	parameter int CW = 67,
	parameter int SW = 139
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] nrm [3],
	input  logic signed [CW-1:0] cof [3],
	input  logic signed [SW-1:0] alpha,
	input  logic signed [W-1:0]  p0,
	output logic [W-1:0]         coord,
	output logic                 ovf
);
	localparam int PW  = NW + CW;
	localparam int NB  = SW + 2;
	localparam int QB  = W + 2;
	localparam int SBW = W + 2;
	localparam logic [QB-1:0] QLIM = {1'b1, {(W+1){1'b0}}};
	localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};

	logic signed [PW-1:0] prod [3];
	logic signed [SW-1:0] num_s4;
	logic [SW-1:0]        nmag, amag;
	logic [NB-1:0]        np, dp, np_s5, dp_s5;
	logic                 neg, large0;
	logic [SBW-1:0]       side_s5, side_d;
	logic [QB-1:0]        quo;
	logic signed [W+2:0]  r;
	logic                 neg_f, too_big, fits;
	logic [W-1:0]         res;

	// cofactor expansion along the replaced column
	for (genvar i = 0; i < 3; i++) begin : g_mul
		tcc_mul #(.AW(NW), .BW(CW)) u_mul (
			.clk(clk), .en(en), .a(nrm[i]), .b(cof[i]), .p(prod[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
		end
	end

	// round to nearest, ties away: (2|n| + 2|a|) / (4|a|)
	always_comb begin
		nmag   = num_s4[SW-1] ? SW'(-num_s4) : SW'(num_s4);
		amag   = alpha[SW-1] ? SW'(-alpha) : SW'(alpha);
		np     = (NB'(nmag) << 1) + (NB'(amag) << 1);
		dp     = NB'(amag) << 2;
		neg    = num_s4[SW-1] ^ alpha[SW-1];
		large0 = {{QB{1'b0}}, np} >= {dp, {QB{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s5   <= np;
			dp_s5   <= dp;
			side_s5 <= {neg, large0, p0};
		end
	end

	tcc_div #(.NB(NB), .QB(QB), .SBW(SBW)) u_div (
		.clk(clk), .en(en), .num(np_s5), .den(dp_s5), .side(side_s5),
		.quo(quo), .side_o(side_d)
	);

	// add the vertex offset and saturate
	always_comb begin
		neg_f   = side_d[W+1];
		too_big = side_d[W] | (quo > QLIM);
		if (neg_f) begin
			r = (W+3)'($signed(side_d[W-1:0])) - $signed({1'b0, quo});
		end else begin
			r = (W+3)'($signed(side_d[W-1:0])) + $signed({1'b0, quo});
		end
		fits = (&r[W+2:W-1]) | ~(|r[W+2:W-1]);
		if (too_big) begin
			res = neg_f ? MINV : MAXV;
		end else if (!fits) begin
			res = r[W+2] ? MINV : MAXV;
		end else begin
			res = r[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coord <= res;
			ovf   <= too_big | ~fits;
		end
	end

endmodule

// ===== rtl/tetra_circumcenter.sv =====
// tetra_circumcenter: top level, shared front end, three axis lanes, output merge
// depends on tcc_pkg, tcc_mul and tcc_lane
//
// Circumcenter of one tetrahedron per word. Vertex coordinates are signed
// fixed point of COORD_WIDTH bits; the result shares their scale, so any
// fraction split works unchanged. Intermediates are exact; the only rounding
// is the final one, to nearest with ties away from zero. A word is accepted
// every cycle while the output side keeps up; the latency is set by the
// chunked determinant multipliers and by the divider that retires one
// quotient bit per stage. All stages advance together, so a held
// output word holds the pipeline behind it. A zero volume gives zero
// coordinates with degenerate set; saturated coordinates set overflow.
module tetra_circumcenter #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vert_valid,
	output logic                          vert_ready,
	input  logic signed [COORD_WIDTH-1:0] p0_x,
	input  logic signed [COORD_WIDTH-1:0] p0_y,
	input  logic signed [COORD_WIDTH-1:0] p0_z,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p1_z,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] p2_z,
	input  logic signed [COORD_WIDTH-1:0] p3_x,
	input  logic signed [COORD_WIDTH-1:0] p3_y,
	input  logic signed [COORD_WIDTH-1:0] p3_z,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic signed [COORD_WIDTH-1:0] cx,
	output logic signed [COORD_WIDTH-1:0] cy,
	output logic signed [COORD_WIDTH-1:0] cz,
	output logic                          degenerate,
	output logic                          overflow
);
	import tcc_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int DW  = W + 1;
	localparam int PW2 = 2 * DW;
	localparam int NW  = 2 * DW + 2;
	localparam int CW  = 2 * DW + 1;
	localparam int SW  = NW + CW + 2;
	localparam int LM  = mul_stages(CW);
	localparam int QB  = W + 2;
	localparam int PD  = LM + 4;
	localparam int DD  = QB + 2;
	localparam int TOT = LM + QB + 7;

	logic                 adv;
	logic [TOT-1:0]       vld_q;
	logic signed [W-1:0]  pin [4][3];
	logic signed [DW-1:0] a_s1 [3][3];
	logic signed [DW-1:0] a0_s2 [3];
	logic signed [DW-1:0] a0_s3 [3];
	logic signed [PW2-1:0] sq_s2 [3][3];
	logic signed [PW2-1:0] mpa_s2 [3][3];
	logic signed [PW2-1:0] mpb_s2 [3][3];
	logic signed [NW-1:0] nrm_s3 [3];
	logic signed [CW-1:0] cof_s3 [3][3];
	logic signed [CW-1:0] cof_col [3][3];
	logic signed [NW+CW-1:0] aprod [3];
	logic signed [SW-1:0] alpha_s4;
	logic signed [W-1:0]  p0_d [PD][3];
	logic [DD-1:0]        deg_d;
	logic [W-1:0]         coord [3];
	logic [2:0]           lovf;

	// whole pipeline moves unless the output word is held
	assign adv        = ~vld_q[TOT-1] | res_ready;
	assign vert_ready = adv;
	assign res_valid  = vld_q[TOT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOT-2:0], vert_valid};
		end
	end

	assign pin[0] = '{p0_x, p0_y, p0_z};
	assign pin[1] = '{p1_x, p1_y, p1_z};
	assign pin[2] = '{p2_x, p2_y, p2_z};
	assign pin[3] = '{p3_x, p3_y, p3_z};

	// edge vectors from vertex 0
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					a_s1[i][j] <= DW'(pin[i+1][j]) - DW'(pin[0][j]);
				end
			end
		end
	end

	// squares and 2x2 minor products
	for (genvar i = 0; i < 3; i++) begin : g_row
		localparam int R1 = (i == 0) ? 1 : 0;
		localparam int R2 = (i == 2) ? 1 : 2;
		for (genvar j = 0; j < 3; j++) begin : g_col
			localparam int C1 = (j == 0) ? 1 : 0;
			localparam int C2 = (j == 2) ? 1 : 2;
			always_ff @(posedge clk) begin
				if (adv) begin
					sq_s2[i][j]  <= a_s1[i][j] * a_s1[i][j];
					mpa_s2[i][j] <= a_s1[R1][C1] * a_s1[R2][C2];
					mpb_s2[i][j] <= a_s1[R1][C2] * a_s1[R2][C1];
				end
			end
			// signed cofactors
			always_ff @(posedge clk) begin
				if (adv) begin
					if (((i + j) % 2) == 1) begin
						cof_s3[i][j] <= CW'(mpb_s2[i][j]) - CW'(mpa_s2[i][j]);
					end else begin
						cof_s3[i][j] <= CW'(mpa_s2[i][j]) - CW'(mpb_s2[i][j]);
					end
				end
			end
			assign cof_col[j][i] = cof_s3[i][j];
		end
	end

	// squared norms, first column carried for the volume term
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nrm_s3[i] <= NW'(sq_s2[i][0]) + NW'(sq_s2[i][1]) + NW'(sq_s2[i][2]);
				a0_s2[i]  <= a_s1[i][0];
				a0_s3[i]  <= a0_s2[i];
			end
		end
	end

	// alpha by expansion along the first column
	for (genvar i = 0; i < 3; i++) begin : g_alpha
		tcc_mul #(.AW(NW), .BW(CW)) u_mul (
			.clk(clk), .en(adv), .a(NW'(a0_s3[i])), .b(cof_s3[i][0]), .p(aprod[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alpha_s4 <= SW'(aprod[0]) + SW'(aprod[1]) + SW'(aprod[2]);
		end
	end

	// vertex 0 delay up to the determinant sums
	always_ff @(posedge clk) begin
		if (adv) begin
			p0_d[0] <= pin[0];
			for (int k = 1; k < PD; k++) begin
				p0_d[k] <= p0_d[k-1];
			end
		end
	end

	// flat flag delay up to the lane outputs
	always_ff @(posedge clk) begin
		if (adv) begin
			deg_d <= {deg_d[DD-2:0], (alpha_s4 == '0)};
		end
	end

	// one lane per axis
	for (genvar k = 0; k < 3; k++) begin : g_lane
		tcc_lane #(.W(W), .NW(NW), .CW(CW), .SW(SW)) u_lane (
			.clk(clk), .en(adv), .nrm(nrm_s3), .cof(cof_col[k]), .alpha(alpha_s4),
			.p0(p0_d[PD-1][k]), .coord(coord[k]), .ovf(lovf[k])
		);
	end

	// merge lanes into the output word
	always_ff @(posedge clk) begin
		if (adv) begin
			degenerate <= deg_d[DD-1];
			if (deg_d[DD-1]) begin
				cx       <= '0;
				cy       <= '0;
				cz       <= '0;
				overflow <= 1'b0;
			end else begin
				cx       <= coord[0];
				cy       <= coord[1];
				cz       <= coord[2];
				overflow <= |lovf;
			end
		end
	end

endmodule
